FILE: rtl/kfi_pkg.sv
`timescale 1ns / 1ps

package kfi_pkg;

	// table and datapath sizes
	localparam int MAX_KEYFRAMES = 256;
	localparam int IDX_W         = $clog2(MAX_KEYFRAMES);
	localparam int CNT_W         = $clog2(MAX_KEYFRAMES + 1);
	localparam int ENTRY_W       = 128;
	localparam int CORDIC_STEPS  = 16;
	localparam int STEP_W        = 5;
	localparam int CW            = 36;
	localparam int QUEUE_DEPTH   = 2;

	// kind codes on the input channel
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_REWIND = 2'd2;

	// degree constants in Q16.16
	localparam logic signed [31:0] DEG90  = 32'sd5898240;
	localparam logic signed [31:0] DEG180 = 32'sd11796480;
	localparam logic signed [31:0] DEG360 = 32'sd23592960;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;

	// arctangent of 2^-i in Q16.16 degrees
	localparam logic [31:0] ATAN_DEG [24] = '{
		32'd2949120, 32'd1740967, 32'd919879, 32'd466945, 32'd234378, 32'd117304,
		32'd58666, 32'd29335, 32'd14668, 32'd7334, 32'd3667, 32'd1833,
		32'd917, 32'd458, 32'd229, 32'd115, 32'd57, 32'd29,
		32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_QUERY  = 2'd1,
		OP_REWIND = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] z;
		logic [31:0] angle;
	} item_t;

	// remainder by 360 through a reciprocal multiply, exact for m up to 32768
	function automatic logic [8:0] mod360(input logic [15:0] m);
		logic [29:0] p;
		logic [7:0]  q;
		logic [16:0] qm;
		p  = 30'(m) * 30'd11651;
		q  = p[29:22];
		qm = 17'(q) * 17'd360;
		return 9'(17'(m) - qm);
	endfunction

endpackage

FILE: rtl/keyframe_pose_interpolator.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        input      in_valid / in_stall    kind, key_time, key_x, key_z, key_angle
// out       output     out_valid / out_stall  pos_x, pos_z, cos_heading, sin_heading,
//                                             segment_index, exact_hit
// cfg       input      cfg_valid / cfg_ready  time_tolerance
//
// load and rewind finish in the sequencer's idle state; a query reads and checks each
// keyframe scanned; a segment then takes a read of its lower key, up to 16 divide steps,
// 3 multiplies and 1 sum; the heading unit then runs CORDIC_STEPS rotation steps.
// a two-beat queue sits in front.
// arst_n clears the table fill, index, held pose, queue and output valid; tolerance is 7.
// a stalled output holds the sequencer while the queue keeps taking input beats until full.

module keyframe_pose_interpolator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [31:0]        key_time,
	input  logic signed [31:0] key_x,
	input  logic signed [31:0] key_z,
	input  logic signed [31:0] key_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] cos_heading,
	output logic signed [15:0] sin_heading,
	output logic [7:0]         segment_index,
	output logic               exact_hit,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        time_tolerance
);

	logic [15:0]    tol_q;
	logic           q_valid;
	logic           q_pop;
	kfi_pkg::item_t q_item;

	// tolerance register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd7;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= time_tolerance;
		end
	end

	kfi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.key_time (key_time),
		.key_x    (key_x),
		.key_z    (key_z),
		.key_angle(key_angle),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	kfi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tol          (tol_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.cos_heading  (cos_heading),
		.sin_heading  (sin_heading),
		.segment_index(segment_index),
		.exact_hit    (exact_hit)
	);

endmodule

FILE: rtl/kfi_ram.sv
`timescale 1ns / 1ps

module kfi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/kfi_front.sv
`timescale 1ns / 1ps

module kfi_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      kind,
	input  logic [31:0]     key_time,
	input  logic [31:0]     key_x,
	input  logic [31:0]     key_z,
	input  logic [31:0]     key_angle,
	output logic            q_valid,
	output kfi_pkg::item_t  q_item,
	input  logic            q_pop
);

	kfi_pkg::item_t fifo_q [kfi_pkg::QUEUE_DEPTH];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;
	logic           acc;
	logic           keep;
	kfi_pkg::op_t   op;

	// classify the kind code, unknown kinds are dropped
	always_comb begin
		op   = kfi_pkg::OP_LOAD;
		keep = 1'b1;
		case (kind)
			kfi_pkg::KIND_LOAD:   op = kfi_pkg::OP_LOAD;
			kfi_pkg::KIND_QUERY:  op = kfi_pkg::OP_QUERY;
			kfi_pkg::KIND_REWIND: op = kfi_pkg::OP_REWIND;
			default:              keep = 1'b0;
		endcase
	end

	assign in_stall = (cnt_q == 2'(kfi_pkg::QUEUE_DEPTH));
	assign acc      = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = fifo_q[rptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (acc && keep) begin
			fifo_q[wptr_q] <= '{op: op, t: key_time, x: key_x, z: key_z, angle: key_angle};
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (acc && keep) begin
				wptr_q <= !wptr_q;
			end
			if (q_pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(acc && keep) - 2'(q_pop);
		end
	end

endmodule

FILE: rtl/kfi_cordic.sv
`timescale 1ns / 1ps

module kfi_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [15:0] cos_out,
	output logic signed [15:0] sin_out
);

	typedef enum logic [4:0] {
		C_IDLE = 5'b00001,
		C_RED  = 5'b00010,
		C_FOLD = 5'b00100,
		C_ITER = 5'b01000,
		C_OUT  = 5'b10000
	} cstate_t;

	cstate_t                 state_q;
	logic signed [31:0]      a_q;
	logic signed [31:0]      r_q;
	logic signed [kfi_pkg::CW-1:0] x_q;
	logic signed [kfi_pkg::CW-1:0] y_q;
	logic [kfi_pkg::STEP_W-1:0]    i_q;
	logic                    flip_q;
	logic                    done_q;
	logic signed [15:0]      cos_q;
	logic signed [15:0]      sin_q;

	logic [32:0]             mag;
	logic [8:0]              rm;
	logic signed [31:0]      m;
	logic signed [31:0]      red;
	logic signed [31:0]      atn;
	logic signed [kfi_pkg::CW-1:0] xs;
	logic signed [kfi_pkg::CW-1:0] ys;
	logic signed [kfi_pkg::CW-1:0] xf;
	logic signed [kfi_pkg::CW-1:0] yf;

	function automatic logic signed [15:0] clamp14(input logic signed [kfi_pkg::CW-1:0] v);
		logic signed [kfi_pkg::CW-1:0] s;
		s = (v + kfi_pkg::CW'(32768)) >>> 16;
		if (s > kfi_pkg::CW'(16384)) begin
			return 16'sd16384;
		end else if (s < -kfi_pkg::CW'(16384)) begin
			return -16'sd16384;
		end
		return 16'(s);
	endfunction

	// reduce into (-180, 180]: remainder of whole degrees, fraction kept
	always_comb begin
		mag = a_q[31] ? (33'd0 - {a_q[31], a_q}) : {1'b0, a_q};
		rm  = kfi_pkg::mod360(mag[31:16]);
		m   = 32'({rm, mag[15:0]});
		red = a_q[31] ? -m : m;
		if (red < 0) begin
			red = red + kfi_pkg::DEG360;
		end
		if (red > kfi_pkg::DEG180) begin
			red = red - kfi_pkg::DEG360;
		end
	end

	// one rotation step
	assign atn = $signed(kfi_pkg::ATAN_DEG[i_q]);
	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign xf  = flip_q ? -x_q : x_q;
	assign yf  = flip_q ? -y_q : y_q;

	assign done    = done_q;
	assign cos_out = cos_q;
	assign sin_out = sin_q;

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					a_q <= angle;
				end
			end
			C_RED: begin
				r_q <= red;
			end
			C_FOLD: begin
				x_q <= kfi_pkg::CORDIC_GAIN;
				y_q <= '0;
				if (r_q > kfi_pkg::DEG90) begin
					r_q    <= r_q - kfi_pkg::DEG180;
					flip_q <= 1'b1;
				end else if (r_q < -kfi_pkg::DEG90) begin
					r_q    <= r_q + kfi_pkg::DEG180;
					flip_q <= 1'b1;
				end else begin
					flip_q <= 1'b0;
				end
			end
			C_ITER: begin
				if (r_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					r_q <= r_q - atn;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					r_q <= r_q + atn;
				end
			end
			C_OUT: begin
				cos_q <= clamp14(xf);
				sin_q <= clamp14(yf);
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			i_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						done_q  <= 1'b0;
						state_q <= C_RED;
					end
				end
				C_RED: state_q <= C_FOLD;
				C_FOLD: begin
					i_q     <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					i_q <= i_q + 1'b1;
					if (i_q == kfi_pkg::STEP_W'(kfi_pkg::CORDIC_STEPS - 1)) begin
						state_q <= C_OUT;
					end
				end
				C_OUT: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/kfi_back.sv
`timescale 1ns / 1ps

module kfi_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        tol,
	input  logic               q_valid,
	input  kfi_pkg::item_t     q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] cos_heading,
	output logic signed [15:0] sin_heading,
	output logic [7:0]         segment_index,
	output logic               exact_hit
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_RD   = 10'b0000000010,
		S_CHK  = 10'b0000000100,
		S_RD0  = 10'b0000001000,
		S_CHK0 = 10'b0000010000,
		S_DIV  = 10'b0000100000,
		S_MUL  = 10'b0001000000,
		S_SUM  = 10'b0010000000,
		S_HEAD = 10'b0100000000,
		S_WAIT = 10'b1000000000
	} bstate_t;

	bstate_t                      state_q;
	logic [kfi_pkg::CNT_W-1:0]    cnt_q;
	logic [kfi_pkg::IDX_W-1:0]    cur_q;
	logic [kfi_pkg::IDX_W-1:0]    idx_q;
	logic [31:0]                  held_x_q;
	logic [31:0]                  held_z_q;
	logic [31:0]                  k0_x_q;
	logic [31:0]                  k0_z_q;
	logic [31:0]                  t_q;
	logic                         zq_q;
	logic [31:0]                  t1_q;
	logic [31:0]                  x1_q;
	logic [31:0]                  z1_q;
	logic signed [31:0]           a1w_q;
	logic signed [31:0]           x0_q;
	logic signed [31:0]           z0_q;
	logic signed [31:0]           a0w_q;
	logic [31:0]                  den_q;
	logic [31:0]                  rem_q;
	logic [16:0]                  alpha_q;
	logic [3:0]                   dcnt_q;
	logic [1:0]                   mcnt_q;
	logic signed [32:0]           dx_q;
	logic signed [32:0]           dz_q;
	logic signed [32:0]           adiff_q;
	logic signed [50:0]           px_q;
	logic signed [50:0]           pz_q;
	logic signed [50:0]           pa_q;
	logic signed [33:0]           res_x_q;
	logic signed [33:0]           res_z_q;
	logic signed [31:0]           res_ang_q;
	logic [kfi_pkg::IDX_W-1:0]    res_idx_q;
	logic                         res_hit_q;
	logic                         out_valid_q;
	logic signed [31:0]           pos_x_q;
	logic signed [31:0]           pos_z_q;
	logic signed [15:0]           cos_q;
	logic signed [15:0]           sin_q;
	logic [7:0]                   seg_q;
	logic                         hit_q;

	logic                         we;
	logic [kfi_pkg::IDX_W-1:0]    waddr;
	logic [kfi_pkg::IDX_W-1:0]    raddr;
	logic [kfi_pkg::ENTRY_W-1:0]  wdata;
	logic [kfi_pkg::ENTRY_W-1:0]  rdata;
	logic [31:0]                  e_t;
	logic [31:0]                  e_x;
	logic [31:0]                  e_z;
	logic [31:0]                  e_a;
	logic [31:0]                  tdelta;
	logic                         near;
	logic                         below;
	logic                         last;
	logic signed [32:0]           num;
	logic signed [32:0]           den;
	logic [32:0]                  rem2;
	logic                         ge;
	logic signed [17:0]           a18;
	logic signed [32:0]           opnd;
	logic signed [50:0]           prod;
	logic signed [34:0]           trx;
	logic signed [34:0]           trz;
	logic signed [31:0]           sha;
	logic                         out_free;
	logic                         cstart;
	logic                         cdone;
	logic signed [15:0]           ccos;
	logic signed [15:0]           csin;

	// keyframe angle wrap: beyond a full turn, whole degrees modulo 360
	function automatic logic signed [31:0] wrap(input logic signed [31:0] a);
		logic [32:0] mag;
		logic [32:0] rnd;
		logic [8:0]  rm;
		logic signed [31:0] v;
		if (a <= kfi_pkg::DEG360 && a >= -kfi_pkg::DEG360) begin
			return a;
		end
		mag = a[31] ? (33'd0 - {a[31], a}) : {1'b0, a};
		rnd = mag + 33'd32768;
		rm  = kfi_pkg::mod360(rnd[31:16]);
		v   = 32'({rm, 16'd0});
		return a[31] ? -v : v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -34'sd2147483648) begin
			return 32'sh80000000;
		end
		return 32'(v);
	endfunction

	// keyframe store: time, x, z, angle side by side
	kfi_ram #(
		.WIDTH(kfi_pkg::ENTRY_W),
		.DEPTH(kfi_pkg::MAX_KEYFRAMES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	kfi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cstart),
		.angle  (res_ang_q),
		.done   (cdone),
		.cos_out(ccos),
		.sin_out(csin)
	);

	assign q_pop  = (state_q == S_IDLE) && q_valid;
	assign we     = q_pop && (q_item.op == kfi_pkg::OP_LOAD)
		&& (cnt_q < kfi_pkg::CNT_W'(kfi_pkg::MAX_KEYFRAMES));
	assign waddr  = cnt_q[kfi_pkg::IDX_W-1:0];
	assign wdata  = {q_item.t, q_item.x, q_item.z, q_item.angle};
	assign raddr  = idx_q;
	assign cstart = (state_q == S_HEAD);

	assign e_t = rdata[127:96];
	assign e_x = rdata[95:64];
	assign e_z = rdata[63:32];
	assign e_a = rdata[31:0];

	// search compare against the entry just read
	assign tdelta = (t_q >= e_t) ? (t_q - e_t) : (e_t - t_q);
	assign near   = tdelta < {16'd0, tol};
	assign below  = t_q < e_t;
	assign last   = (kfi_pkg::CNT_W'(idx_q) + 1'b1) >= cnt_q;

	// segment alpha terms
	assign num = $signed({1'b0, t_q}) - $signed({1'b0, e_t});
	assign den = $signed({1'b0, t1_q}) - $signed({1'b0, e_t});

	// restoring divide step
	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	// shared multiplier
	assign a18 = $signed({1'b0, alpha_q});
	always_comb begin
		case (mcnt_q)
			2'd0:    opnd = dx_q;
			2'd1:    opnd = dz_q;
			default: opnd = adiff_q;
		endcase
	end
	assign prod = a18 * opnd;

	// products truncated toward zero
	assign trx = (px_q < 0) ? 35'((px_q + 51'sd65535) >>> 16) : 35'(px_q >>> 16);
	assign trz = (pz_q < 0) ? 35'((pz_q + 51'sd65535) >>> 16) : 35'(pz_q >>> 16);
	assign sha = 32'(pa_q >>> 16);

	assign out_free = !out_valid_q || !out_stall;

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					t_q  <= q_item.t;
					zq_q <= (q_item.t == 32'd0);
					if (we && cnt_q == '0) begin
						k0_x_q <= q_item.x;
						k0_z_q <= q_item.z;
					end
				end
			end
			S_CHK: begin
				if (zq_q) begin
					res_x_q   <= 34'($signed(held_x_q));
					res_z_q   <= 34'($signed(held_z_q));
					res_ang_q <= $signed(e_a);
					res_idx_q <= cur_q;
					res_hit_q <= 1'b1;
				end else if (near || (below && idx_q == '0) || (!below && last)) begin
					res_x_q   <= 34'($signed(e_x));
					res_z_q   <= 34'($signed(e_z));
					res_ang_q <= $signed(e_a);
					res_idx_q <= idx_q;
					res_hit_q <= 1'b1;
				end else if (below) begin
					t1_q  <= e_t;
					x1_q  <= e_x;
					z1_q  <= e_z;
					a1w_q <= wrap($signed(e_a));
				end
			end
			S_CHK0: begin
				x0_q      <= $signed(e_x);
				z0_q      <= $signed(e_z);
				a0w_q     <= wrap($signed(e_a));
				dx_q      <= 33'($signed(x1_q)) - 33'($signed(e_x));
				dz_q      <= 33'($signed(z1_q)) - 33'($signed(e_z));
				res_idx_q <= idx_q;
				res_hit_q <= 1'b0;
				rem_q     <= num[31:0];
				den_q     <= den[31:0];
				if (den <= 0 || num <= 0) begin
					alpha_q <= 17'd0;
				end else if (num >= den) begin
					alpha_q <= 17'd65536;
				end else begin
					alpha_q <= 17'd0;
				end
			end
			S_DIV: begin
				rem_q   <= ge ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
				alpha_q <= {alpha_q[15:0], ge};
			end
			S_MUL: begin
				case (mcnt_q)
					2'd0: begin
						px_q    <= prod;
						adiff_q <= (a1w_q > a0w_q) ? 33'(a1w_q) - 33'(a0w_q)
							: 33'(a0w_q) - 33'(a1w_q);
					end
					2'd1:    pz_q <= prod;
					default: pa_q <= prod;
				endcase
			end
			S_SUM: begin
				res_x_q   <= 34'(x0_q) + 34'(trx);
				res_z_q   <= 34'(z0_q) + 34'(trz);
				res_ang_q <= (a0w_q < a1w_q) ? a0w_q + sha : a0w_q - sha;
			end
			default: begin
			end
		endcase
		// output register
		if (state_q == S_WAIT && cdone && out_free) begin
			pos_x_q <= sat32(res_x_q);
			pos_z_q <= sat32(res_z_q);
			cos_q   <= ccos;
			sin_q   <= csin;
			seg_q   <= 8'(res_idx_q);
			hit_q   <= res_hit_q;
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			held_x_q    <= '0;
			held_z_q    <= '0;
			dcnt_q      <= '0;
			mcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						case (q_item.op)
							kfi_pkg::OP_LOAD: begin
								if (we) begin
									cnt_q <= cnt_q + 1'b1;
									if (cnt_q == '0) begin
										held_x_q <= q_item.x;
										held_z_q <= q_item.z;
									end
								end
							end
							kfi_pkg::OP_REWIND: begin
								cur_q    <= '0;
								held_x_q <= (cnt_q != '0) ? k0_x_q : 32'd0;
								held_z_q <= (cnt_q != '0) ? k0_z_q : 32'd0;
							end
							kfi_pkg::OP_QUERY: begin
								if (cnt_q != '0) begin
									idx_q   <= (kfi_pkg::CNT_W'(cur_q) < cnt_q) ? cur_q
										: kfi_pkg::IDX_W'(cnt_q - 1'b1);
									state_q <= S_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (zq_q) begin
						state_q <= S_HEAD;
					end else if (near || (below && idx_q == '0) || (!below && last)) begin
						cur_q    <= idx_q;
						held_x_q <= e_x;
						held_z_q <= e_z;
						state_q  <= S_HEAD;
					end else if (below) begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_RD0;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_RD0: state_q <= S_CHK0;
				S_CHK0: begin
					cur_q  <= idx_q;
					dcnt_q <= '0;
					mcnt_q <= '0;
					if (den <= 0 || num <= 0 || num >= den) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 4'd15) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 2'd2) begin
						state_q <= S_SUM;
					end
				end
				S_SUM:  state_q <= S_HEAD;
				S_HEAD: state_q <= S_WAIT;
				S_WAIT: begin
					if (cdone && out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign pos_x         = pos_x_q;
	assign pos_z         = pos_z_q;
	assign cos_heading   = cos_q;
	assign sin_heading   = sin_q;
	assign segment_index = seg_q;
	assign exact_hit     = hit_q;

endmodule

FILE: test/tb_keyframe_pose_interpolator.sv
`timescale 1ns / 1ps

module tb_keyframe_pose_interpolator;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 120;
	localparam int IDLE_LIMIT    = 6000;
	localparam int LONG_HOLD     = 400;

	typedef struct {
		logic [31:0] px;
		logic [31:0] pz;
		logic [15:0] c;
		logic [15:0] s;
		logic [7:0]  seg;
		logic        hit;
	} pose_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         kind;
	logic [31:0]        key_time;
	logic signed [31:0] key_x;
	logic signed [31:0] key_z;
	logic signed [31:0] key_angle;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_z;
	logic signed [15:0] cos_heading;
	logic signed [15:0] sin_heading;
	logic [7:0]         segment_index;
	logic               exact_hit;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [15:0]        time_tolerance;

	keyframe_pose_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .key_time(key_time), .key_x(key_x), .key_z(key_z),
		.key_angle(key_angle),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_z(pos_z), .cos_heading(cos_heading),
		.sin_heading(sin_heading), .segment_index(segment_index),
		.exact_hit(exact_hit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .time_tolerance(time_tolerance)
	);

	// shadow keyframe table and pose state
	logic [31:0] kf_time  [kfi_pkg::MAX_KEYFRAMES];
	logic [31:0] kf_x     [kfi_pkg::MAX_KEYFRAMES];
	logic [31:0] kf_z     [kfi_pkg::MAX_KEYFRAMES];
	logic [31:0] kf_angle [kfi_pkg::MAX_KEYFRAMES];
	int unsigned kf_count;
	int unsigned cur_idx;
	logic [63:0] held;
	int unsigned tol;

	pose_t expected_poses[$];
	int    errors;
	bit    calm;
	bit    long_hold;
	int    idle_cycles;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint sx32(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round14(longint v);
		longint r;
		r = (v + 32768) >>> 16;
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r;
	endfunction

	// append a predicted pose at the tail of the queue
	function automatic void queue_pose(pose_t p);
		expected_poses.insert(expected_poses.size(), p);
	endfunction

	// whole-degree reduction for headings beyond a full turn
	function automatic longint wrap_deg(longint a);
		longint r;
		if (a <= longint'(kfi_pkg::DEG360) && a >= -longint'(kfi_pkg::DEG360)) return a;
		r = (a >= 0) ? ((a + 32768) >>> 16) : -((-a + 32768) >>> 16);
		r = r % 360;
		return r * 65536;
	endfunction

	function automatic pose_t make_pose(longint x, longint z, longint ang,
			int unsigned seg, logic hit);
		pose_t  p;
		longint r, cx, cy, nx;
		bit     flip;
		r    = ang % longint'(kfi_pkg::DEG360);
		cx   = longint'(kfi_pkg::CORDIC_GAIN);
		cy   = 0;
		flip = 1'b0;
		if (r < 0) r += longint'(kfi_pkg::DEG360);
		if (r > longint'(kfi_pkg::DEG180)) r -= longint'(kfi_pkg::DEG360);
		if (r > longint'(kfi_pkg::DEG90)) begin
			r -= longint'(kfi_pkg::DEG180);
			flip = 1'b1;
		end else if (r < -longint'(kfi_pkg::DEG90)) begin
			r += longint'(kfi_pkg::DEG180);
			flip = 1'b1;
		end
		// rotate towards zero residual angle
		for (int i = 0; i < kfi_pkg::CORDIC_STEPS && i < 24; i++) begin
			if (r >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				r -= longint'(kfi_pkg::ATAN_DEG[i]);
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				r += longint'(kfi_pkg::ATAN_DEG[i]);
			end
			cx = nx;
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		p.px  = 32'(sat32(x));
		p.pz  = 32'(sat32(z));
		p.c   = 16'(round14(cx));
		p.s   = 16'(round14(cy));
		p.seg = 8'(seg);
		p.hit = hit;
		return p;
	endfunction

	// update shadow state for one accepted beat, queue the pose it produces
	task automatic predict_pose(logic [1:0] k, logic [31:0] t, logic [31:0] x,
			logic [31:0] z, logic [31:0] a);
		int unsigned idx, lo;
		logic [31:0] kt, tdelta;
		longint      num, den, alpha, x0, z0, a0, a1, diff, ang;
		bit          found;
		case (k)
			kfi_pkg::OP_LOAD: begin
				if (kf_count < kfi_pkg::MAX_KEYFRAMES) begin
					kf_time[kf_count]  = t;
					kf_x[kf_count]     = x;
					kf_z[kf_count]     = z;
					kf_angle[kf_count] = a;
					if (kf_count == 0) held = {x, z};
					kf_count++;
				end
			end
			kfi_pkg::OP_REWIND: begin
				cur_idx = 0;
				held    = kf_count ? {kf_x[0], kf_z[0]} : 64'd0;
			end
			kfi_pkg::OP_QUERY: begin
				if (kf_count != 0) begin
					idx = (cur_idx < kf_count) ? cur_idx : kf_count - 1;
					if (t == 0) begin
						queue_pose(make_pose(sx32(held[63:32]),
							sx32(held[31:0]), sx32(kf_angle[idx]), cur_idx, 1'b1));
					end else begin
						found = 1'b0;
						// forward search from the current keyframe
						while (!found) begin
							if (idx >= kf_count) begin
								idx   = kf_count - 1;
								found = 1'b1;
							end else begin
								kt     = kf_time[idx];
								tdelta = (t >= kt) ? t - kt : kt - t;
								if (tdelta < tol) found = 1'b1;
								else if (t < kt) begin
									if (idx == 0) found = 1'b1;
									else break;
								end else idx++;
							end
						end
						if (found) begin
							cur_idx = idx;
							held    = {kf_x[idx], kf_z[idx]};
							queue_pose(make_pose(sx32(kf_x[idx]),
								sx32(kf_z[idx]), sx32(kf_angle[idx]), idx, 1'b1));
						end else begin
							// interpolate inside the segment below idx
							lo  = idx - 1;
							num = longint'(t) - longint'(kf_time[lo]);
							den = longint'(kf_time[idx]) - longint'(kf_time[lo]);
							if (den <= 0 || num <= 0) alpha = 0;
							else if (num >= den) alpha = 65536;
							else alpha = (num * 65536) / den;
							x0 = sx32(kf_x[lo]);
							z0 = sx32(kf_z[lo]);
							x0 += (alpha * (sx32(kf_x[idx]) - x0)) / 65536;
							z0 += (alpha * (sx32(kf_z[idx]) - z0)) / 65536;
							a0 = wrap_deg(sx32(kf_angle[lo]));
							a1 = wrap_deg(sx32(kf_angle[idx]));
							diff = (a1 > a0) ? a1 - a0 : a0 - a1;
							ang  = (alpha * diff) >>> 16;
							ang  = (a0 < a1) ? a0 + ang : a0 - ang;
							cur_idx = lo;
							queue_pose(make_pose(x0, z0, ang, lo, 1'b0));
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// offer one beat and wait until it is taken
	task automatic send_beat(logic [1:0] k, logic [31:0] t, logic [31:0] x,
			logic [31:0] z, logic [31:0] a);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		key_time  <= t;
		key_x     <= x;
		key_z     <= z;
		key_angle <= a;
		do @(posedge clk); while (in_stall);
		predict_pose(k, t, x, z, a);
	endtask

	// drain everything, let loads and rewinds finish, then write the tolerance
	task automatic set_tolerance(logic [15:0] v);
		in_valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid      <= 1'b1;
		time_tolerance <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tol = v;
	endtask

	function automatic logic [31:0] deg(int d);
		return 32'(d * 65536);
	endfunction

	task automatic test_empty_table();
		send_beat(kfi_pkg::OP_QUERY, 32'd65536, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_REWIND, 32'd0, 32'd0, 32'd0, 32'd0);
		send_beat(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_directed();
		send_beat(kfi_pkg::OP_LOAD, 32'h000A_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0190_9999);
		send_beat(kfi_pkg::OP_LOAD, 32'h0014_0000, 32'h8000_0000, 32'h7FFF_FFFF, deg(-725));
		send_beat(kfi_pkg::OP_LOAD, 32'h001E_0000, 32'h0001_0000, 32'hFFFF_0000, deg(90));
		send_beat(kfi_pkg::OP_LOAD, 32'h0028_0000, 32'h0010_0000, 32'h0000_8000, deg(179));
		send_beat(kfi_pkg::OP_LOAD, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, deg(-180));
		send_beat(kfi_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h0005_0000, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h000A_0000, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h000F_0000, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h0019_0000, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h0023_4567, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_REWIND, 32'd0, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h000A_0003, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 32'd0);
		send_beat(KIND_UNUSED, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h0014_0000, 32'd0, 32'd0, 32'd0);
	endtask

	// mostly ascending walks with rewinds, a share of loads and noise
	task automatic test_random_walk(int count, bit pressure);
		logic [31:0] walk, last, t;
		int          sel, pick;
		walk = 0;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
			if (pressure && n == count / 2) long_hold = 1'b1;
			last = kf_time[kf_count - 1];
			sel  = $urandom_range(0, 99);
			if (sel < 12 && kf_count < kfi_pkg::MAX_KEYFRAMES - 60) begin
				t = last + $urandom_range(1, 24'hFF_FFFF);
				if (t < last) t = last;
				send_beat(kfi_pkg::OP_LOAD, t,
					$urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 8000)) - 4000),
					$urandom,
					$urandom_range(0, 2) ? deg($urandom_range(0, 1440) - 720) : $urandom);
			end else if (sel < 22) begin
				walk = 0;
				send_beat(kfi_pkg::OP_REWIND, $urandom, $urandom, $urandom, $urandom);
			end else if (sel < 25) begin
				send_beat(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
			end else if (sel < 30) begin
				send_beat(kfi_pkg::OP_QUERY, 32'd0, $urandom, $urandom, $urandom);
			end else if (sel < 38) begin
				send_beat(kfi_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom);
			end else if (sel < 50) begin
				pick = $urandom_range(0, kf_count - 1);
				t = kf_time[pick] + $urandom_range(0, 10) - 5;
				walk = t;
				send_beat(kfi_pkg::OP_QUERY, t, 32'd0, 32'd0, 32'd0);
			end else begin
				walk = walk + $urandom_range(1, 24'hFF_FFFF);
				if (walk > last + 32'h0010_0000 || walk < 32'h0001_0000) walk = kf_time[0];
				send_beat(kfi_pkg::OP_QUERY, walk, 32'd0, 32'd0, 32'd0);
			end
		end
		calm = 1'b0;
	endtask

	// fill the table to the brim, one load past it, then query the far end
	task automatic test_full_table();
		logic [31:0] t;
		send_beat(kfi_pkg::OP_REWIND, 32'd0, 32'd0, 32'd0, 32'd0);
		while (kf_count < kfi_pkg::MAX_KEYFRAMES) begin
			t = kf_time[kf_count - 1] + 32'h0000_1000;
			send_beat(kfi_pkg::OP_LOAD, t, $urandom, $urandom,
				deg($urandom_range(0, 720) - 360));
			if (kf_count % 32 == 0)
				send_beat(kfi_pkg::OP_QUERY, t + 32'h800, 32'd0, 32'd0, 32'd0);
		end
		send_beat(kfi_pkg::OP_LOAD, 32'h0000_0001, 32'h1234_5678, 32'h1234_5678, deg(45));
		send_beat(kfi_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, kf_time[kfi_pkg::MAX_KEYFRAMES - 1], 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, kf_time[kfi_pkg::MAX_KEYFRAMES - 2] + 32'h0000_0800,
			32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_REWIND, 32'd0, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 32'd0);
	endtask

	// stimulus sequence
	initial begin
		errors    = 0;
		calm      = 1'b0;
		long_hold = 1'b0;
		kf_count  = 0;
		cur_idx   = 0;
		held      = 64'd0;
		tol       = 7;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		kind           <= kfi_pkg::OP_LOAD;
		key_time       <= 32'd0;
		key_x          <= 32'd0;
		key_z          <= 32'd0;
		key_angle      <= 32'd0;
		cfg_valid      <= 1'b0;
		time_tolerance <= 16'd7;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_directed();
		set_tolerance(16'd0);
		test_directed_tolerance_sweep();
		set_tolerance(16'd7);
		test_random_walk(50, 1'b1);
		set_tolerance(16'hFFFF);
		test_random_walk(50, 1'b0);
		set_tolerance(16'($urandom));
		test_random_walk(50, 1'b0);
		set_tolerance(16'($urandom_range(0, 64)));
		test_random_walk(50, 1'b1);
		set_tolerance(16'd7);
		test_full_table();

		in_valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// a few queries at and just past keyframe times, right at the tolerance edge
	task automatic test_directed_tolerance_sweep();
		send_beat(kfi_pkg::OP_REWIND, 32'd0, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h000A_0000, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h0014_0001, 32'd0, 32'd0, 32'd0);
		send_beat(kfi_pkg::OP_QUERY, 32'h001E_0000, 32'd0, 32'd0, 32'd0);
	endtask

	// result sink with random stalls and two long hold-offs
	initial begin
		int k;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end
			k = calm ? 0 : $urandom_range(0, 7);
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall) && !long_hold);
		end
	end

	task automatic compare_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
			errors++;
		end
	endtask

	// compare each result beat with the oldest predicted pose
	always @(posedge clk) begin
		pose_t e;
		if (out_valid && !out_stall) begin
			if (expected_poses.size() == 0) begin
				$display("%0t: unexpected result beat, actual pos_x %h", $time, pos_x);
				errors++;
			end else begin
				e = expected_poses.pop_front();
				compare_field("pos_x", e.px, pos_x);
				compare_field("pos_z", e.pz, pos_z);
				compare_field("cos_heading", 32'(e.c), 32'($unsigned(cos_heading)));
				compare_field("sin_heading", 32'(e.s), 32'($unsigned(sin_heading)));
				compare_field("segment_index", 32'(e.seg), 32'(segment_index));
				compare_field("exact_hit", 32'(e.hit), 32'(exact_hit));
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

FILE: keyframe_pose_interpolator.f
rtl/kfi_pkg.sv
rtl/kfi_ram.sv
rtl/kfi_front.sv
rtl/kfi_cordic.sv
rtl/kfi_back.sv
rtl/keyframe_pose_interpolator.sv
test/tb_keyframe_pose_interpolator.sv
